// ===== rtl/sbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared constants, register codes and constant functions of the bottom
// percolation pipeline.
// ----------------------------------------------------------------------------
package sbp_pkg;

	localparam int TAG_W      = 24;
	localparam int COND_W     = 20;
	localparam int GAIN_W     = 16;
	localparam int LCOUNT_W   = 2;
	localparam int HEAD_W     = 20;
	localparam int LAMBDA_W   = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int GAIN_SHIFT   = 12;
	localparam int FRONT_MARGIN = 1000;
	localparam int LCOUNT_MULTI = 2;

	// exponent 3 + 2/lambda in Q16
	localparam int  LOG_FRAC = 16;
	localparam int  E_QW     = 30;
	localparam int  E_W      = 30;
	localparam int  E_BASE   = 3 << LOG_FRAC;
	localparam longint E_NUM = 64'd2 << 28;

	// 2^-x product
	localparam int EXP_R_W   = 33;
	localparam int EXP_C_W   = 32;
	localparam int EXP_LIMIT = 33;

	localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd4096;
	localparam logic [LCOUNT_W-1:0] LCOUNT_RST = 2'd1;
	localparam logic [HEAD_W-1:0]   HEAD_RST   = 20'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 2'd0,
		REG_LCOUNT = 2'd1,
		REG_GW_EN  = 2'd2,
		REG_HEAD   = 2'd3
	} cfg_reg_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		b   = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// factor 2^-(2^-k) in Q32
	function automatic logic [EXP_C_W-1:0] exp_const(input int k);
		logic [63:0] c;
		int i;
		c = isqrt64(64'h8000_0000_0000_0000);
		for (i = 1; i < k; i++) c = isqrt64(c << 32);
		return c[EXP_C_W-1:0];
	endfunction

endpackage

// ===== rtl/sbp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_if
// Channel interfaces: cell requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface sbp_cell_if #(
	parameter int FRACTION_BITS = 16,
	parameter int DEPTH_BITS    = 24
);
	logic                             valid;
	logic                             ready;
	logic [sbp_pkg::TAG_W-1:0]        cell_index;
	logic [DEPTH_BITS-1:0]            front_depth;
	logic [FRACTION_BITS-1:0]         porosity;
	logic [FRACTION_BITS-1:0]         residual_moisture;
	logic [FRACTION_BITS-1:0]         moisture_now;
	logic [FRACTION_BITS-1:0]         field_capacity;
	logic [sbp_pkg::COND_W-1:0]       conductivity;
	logic [sbp_pkg::LAMBDA_W-1:0]     pore_index;
	logic [DEPTH_BITS-1:0]            layer_bottom;
	logic [DEPTH_BITS-1:0]            layer_top;
	logic [DEPTH_BITS-1:0]            groundwater_height;

	modport source (
		output valid, cell_index, front_depth, porosity, residual_moisture, moisture_now,
		output field_capacity, conductivity, pore_index, layer_bottom, layer_top,
		output groundwater_height,
		input  ready
	);
	modport sink (
		input  valid, cell_index, front_depth, porosity, residual_moisture, moisture_now,
		input  field_capacity, conductivity, pore_index, layer_bottom, layer_top,
		input  groundwater_height,
		output ready
	);
endinterface

interface sbp_res_if #(
	parameter int FRACTION_BITS = 16,
	parameter int DEPTH_BITS    = 24
);
	logic                      valid;
	logic                      ready;
	logic [sbp_pkg::TAG_W-1:0] cell_tag;
	logic [DEPTH_BITS-1:0]     percolation;
	logic [FRACTION_BITS-1:0]  moisture_next;
	logic [DEPTH_BITS-1:0]     front_next;

	modport source (output valid, cell_tag, percolation, moisture_next, front_next,
		input ready);
	modport sink (input valid, cell_tag, percolation, moisture_next, front_next,
		output ready);
endinterface

interface sbp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sbp_pkg::CFG_IDX_W-1:0]  index;
	logic [sbp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sbp_delay.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_delay
// Stallable delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module sbp_delay #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	generate
		if (N == 0) begin : g_pass
			assign q = d;
		end else begin : g_line
			logic [W-1:0] tap_s [N];
			always_ff @(posedge clk) begin
				if (en) begin
					tap_s[0] <= d;
					for (int i = 1; i < N; i++) tap_s[i] <= tap_s[i-1];
				end
			end
			assign q = tap_s[N-1];
		end
	endgenerate
endmodule

// ===== rtl/sbp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_div
// Pipelined restoring divider, one quotient bit per stage. The upper DW
// bits of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module sbp_div #(
	parameter int DW = 16,
	parameter int QW = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [QW+DW-1:0] num,
	input  logic [DW-1:0]    den,
	output logic [QW-1:0]    quo
);
	logic [DW-1:0] r_s   [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] lo_s  [QW];
	logic [QW-1:0] q_s   [QW];

	generate
		for (genvar k = 0; k < QW; k++) begin : g_stage
			logic [DW-1:0] r_in;
			logic [DW-1:0] den_in;
			logic [QW-1:0] lo_in;
			logic [QW-1:0] q_in;
			logic [DW:0]   t;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign r_in   = num[QW+DW-1:QW];
				assign den_in = den;
				assign lo_in  = num[QW-1:0];
				assign q_in   = '0;
			end else begin : g_next
				assign r_in   = r_s[k-1];
				assign den_in = den_s[k-1];
				assign lo_in  = lo_s[k-1];
				assign q_in   = q_s[k-1];
			end

			assign t    = {r_in, lo_in[QW-1-k]};
			assign ge   = t >= {1'b0, den_in};
			assign diff = t - {1'b0, den_in};

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k]   <= ge ? diff[DW-1:0] : t[DW-1:0];
					den_s[k] <= den_in;
					lo_s[k]  <= lo_in;
					q_s[k]   <= (q_in << 1) | QW'(ge);
				end
			end
		end
	endgenerate

	assign quo = q_s[QW-1];
endmodule

// ===== rtl/sbp_log.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_log
// -log2 of a relative saturation: normalize, then one squaring per
// fraction bit of the result.
// ----------------------------------------------------------------------------
module sbp_log #(
	parameter int FRACTION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [FRACTION_BITS:0]             se,
	output logic [$clog2(FRACTION_BITS+1)-1:0] n,
	output logic [sbp_pkg::LOG_FRAC-1:0]       frac
);
	import sbp_pkg::*;

	localparam int FB  = FRACTION_BITS;
	localparam int NBW = $clog2(FB + 1);

	logic [FB:0]         m_s [LOG_FRAC+1];
	logic [NBW-1:0]      n_s [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] f_s [LOG_FRAC+1];

	logic [NBW-1:0] n_c;

	always_comb begin
		n_c = '0;
		for (int i = 0; i <= FB; i++) begin
			if (se[i]) n_c = NBW'(FB - i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= se << n_c;
			n_s[0] <= n_c;
			f_s[0] <= '0;
		end
	end

	generate
		for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
			logic [2*FB+1:0] sq;
			logic [FB+1:0]   mm;
			assign sq = {{(FB+1){1'b0}}, m_s[k-1]} * {{(FB+1){1'b0}}, m_s[k-1]};
			assign mm = sq[2*FB+1:FB];
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[k] <= mm[FB+1] ? mm[FB+1:1] : mm[FB:0];
					n_s[k] <= n_s[k-1];
					f_s[k] <= f_s[k-1] | (LOG_FRAC'(mm[FB+1]) << (LOG_FRAC - k));
				end
			end
		end
	endgenerate

	assign n    = n_s[LOG_FRAC];
	assign frac = f_s[LOG_FRAC];
endmodule

// ===== rtl/sbp_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_exp
// 2^-x product of root-of-two constants, one fraction bit per stage; the
// integer part travels alongside for the final shift.
// ----------------------------------------------------------------------------
module sbp_exp #(
	parameter int P_W = 35
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [P_W-1:0]                    p,
	output logic [sbp_pkg::EXP_R_W-1:0]       r,
	output logic [P_W-sbp_pkg::LOG_FRAC-1:0]  ip
);
	import sbp_pkg::*;

	localparam int IW = P_W - LOG_FRAC;
	localparam int MW = EXP_R_W + EXP_C_W;

	logic [EXP_R_W-1:0]  r_s  [LOG_FRAC];
	logic [IW-1:0]       ip_s [LOG_FRAC];
	logic [LOG_FRAC-1:0] f_s  [LOG_FRAC];

	generate
		for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_mul
			localparam logic [EXP_C_W-1:0] C = exp_const(k);
			logic [EXP_R_W-1:0]  r_in;
			logic [IW-1:0]       ip_in;
			logic [LOG_FRAC-1:0] f_in;
			logic [MW-1:0]       prod;

			if (k == 1) begin : g_first
				assign r_in  = EXP_R_W'(1) << EXP_C_W;
				assign ip_in = p[P_W-1:LOG_FRAC];
				assign f_in  = p[LOG_FRAC-1:0];
			end else begin : g_next
				assign r_in  = r_s[k-2];
				assign ip_in = ip_s[k-2];
				assign f_in  = f_s[k-2];
			end

			assign prod = MW'(r_in) * MW'(C);

			always_ff @(posedge clk) begin
				if (en) begin
					r_s[k-1]  <= f_in[LOG_FRAC-k] ? prod[MW-1:EXP_C_W] : r_in;
					ip_s[k-1] <= ip_in;
					f_s[k-1]  <= f_in;
				end
			end
		end
	endgenerate

	assign r  = r_s[LOG_FRAC-1];
	assign ip = ip_s[LOG_FRAC-1];
endmodule

// ===== rtl/soil_bottom_percolation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soil_bottom_percolation
// Brooks-Corey bottom percolation of the lowest soil layer, one cell per
// request, as a deep pipeline.
// ----------------------------------------------------------------------------
// cells: one request per grid cell (lowest layer state and bounds); results:
// one result per request, in request order, with the cell tag echoed.
// cfg: register writes (gain, layer count, groundwater enable, head margin),
// always ready; write only while no request is in flight.
// The path from request to result is set by the lambda divider or the log
// squaring chain, then the 2^-x product chain and the moisture divider.
// Throughput is one request per cycle. All stages move on one enable; the
// output register holds a result until taken, and while the receiver stalls
// the whole pipeline holds and cells.ready stays low.
// Reset clears the valid bits of every stage and the output, and sets the
// registers to gain 1.0, one layer, groundwater off and a 1000 um margin.
// ----------------------------------------------------------------------------
module soil_bottom_percolation #(
	parameter int FRACTION_BITS = 16,
	parameter int DEPTH_BITS    = 24
) (
	input logic        clk,
	input logic        arst_n,
	sbp_cell_if.sink   cells,
	sbp_res_if.source  results,
	sbp_cfg_if.sink    cfg
);
	import sbp_pkg::*;

	localparam int FB     = FRACTION_BITS;
	localparam int DB     = DEPTH_BITS;
	localparam int NBW    = $clog2(FB + 1);
	localparam int LW     = NBW + LOG_FRAC;
	localparam int PRW    = E_W + LW - LOG_FRAC;
	localparam int IW     = PRW - LOG_FRAC;
	localparam int PROD_W = COND_W + GAIN_W;
	localparam int HW     = ((DB > HEAD_W) ? DB : HEAD_W) + 1;
	localparam int SW     = DB + FB;
	localparam int EN_W   = E_QW + LAMBDA_W;

	localparam int T_LOG  = FB + 1 + LOG_FRAC;
	localparam int TM     = (E_QW > T_LOG) ? E_QW : T_LOG;
	localparam int T_P    = TM + 1;
	localparam int T_EXP  = T_P + LOG_FRAC;
	localparam int T_PW   = T_EXP + 1;
	localparam int T_PERC = T_PW + 1;
	localparam int T_MIN  = T_PERC + 1;
	localparam int TF     = T_MIN + FB;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [DB-1:0]    front;
		logic [FB-1:0]    theta;
		logic [FB-1:0]    thr;
		logic [FB-1:0]    fc;
		logic [DB-1:0]    ksat;
		logic             skip;
		logic             fb;
		logic             dlz;
		logic             dsat;
	} side_t;

	// configuration
	logic [GAIN_W-1:0]   gain_q;
	logic [LCOUNT_W-1:0] lcount_q;
	logic                gw_en_q;
	logic [HEAD_W-1:0]   min_head_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= GAIN_RST;
			lcount_q   <= LCOUNT_RST;
			gw_en_q    <= 1'b0;
			min_head_q <= HEAD_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_GAIN:   gain_q     <= cfg.data[GAIN_W-1:0];
				REG_LCOUNT: lcount_q   <= cfg.data[LCOUNT_W-1:0];
				REG_GW_EN:  gw_en_q    <= cfg.data[0];
				REG_HEAD:   min_head_q <= cfg.data[HEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic          en;
	logic          out_vld_q;
	logic [TF+1:0] vld_s;

	assign en          = !out_vld_q || results.ready;
	assign cells.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[TF:0], cells.valid};
			out_vld_q <= vld_s[TF+1];
		end
	end

	// stage 1: capture, gain product, blocking tests
	logic [TAG_W-1:0]    tag_s1;
	logic [DB-1:0]       front_s1, bottom_s1, top_s1;
	logic [FB-1:0]       pore_s1, thr_s1, theta_s1, fc_s1;
	logic [LAMBDA_W-1:0] lam_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic                skip_s1;
	logic                gw_block;

	assign gw_block = gw_en_q && ((HW'(cells.groundwater_height) + HW'(min_head_q))
		> HW'(cells.layer_bottom));

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1    <= cells.cell_index;
			front_s1  <= cells.front_depth;
			pore_s1   <= cells.porosity;
			thr_s1    <= cells.residual_moisture;
			theta_s1  <= cells.moisture_now;
			fc_s1     <= cells.field_capacity;
			lam_s1    <= (cells.pore_index == '0) ? LAMBDA_W'(1) : cells.pore_index;
			bottom_s1 <= cells.layer_bottom;
			top_s1    <= (lcount_q >= LCOUNT_W'(LCOUNT_MULTI)) ? cells.layer_top : '0;
			prod_s1   <= PROD_W'(cells.conductivity) * PROD_W'(gain_q);
			skip_s1   <= gw_block || (cells.moisture_now <= cells.residual_moisture);
		end
	end

	// stage 2: ksat, divider operands, front geometry
	logic [PROD_W-1:0]   ksat_w;
	logic [DB-1:0]       upper;
	logic [FB-1:0]       a_c, den_se_c;
	logic [TAG_W-1:0]    tag_s2;
	logic [DB-1:0]       front_s2, ksat_s2, dl_s2;
	logic [FB-1:0]       theta_s2, thr_s2, fc_s2, a_s2, den_se_s2, den_fc_s2;
	logic [LAMBDA_W-1:0] lam_s2;
	logic                skip_s2, se_full_s2, fb_s2, dlz_s2, fc_sat_s2;

	assign ksat_w   = prod_s1 >> GAIN_SHIFT;
	assign upper    = (top_s1 > front_s1) ? top_s1 : front_s1;
	assign a_c      = theta_s1 - thr_s1;
	assign den_se_c = pore_s1 - thr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2     <= tag_s1;
			front_s2   <= front_s1;
			theta_s2   <= theta_s1;
			thr_s2     <= thr_s1;
			fc_s2      <= fc_s1;
			lam_s2     <= lam_s1;
			skip_s2    <= skip_s1;
			ksat_s2    <= (ksat_w > PROD_W'({DB{1'b1}})) ? {DB{1'b1}} : ksat_w[DB-1:0];
			a_s2       <= a_c;
			den_se_s2  <= den_se_c;
			se_full_s2 <= (pore_s1 <= thr_s1) || (a_c >= den_se_c);
			fb_s2      <= ({1'b0, front_s1} + (DB+1)'(FRONT_MARGIN)) < {1'b0, bottom_s1};
			dlz_s2     <= upper >= bottom_s1;
			dl_s2      <= bottom_s1 - upper;
			den_fc_s2  <= pore_s1 - fc_s1;
			fc_sat_s2  <= pore_s1 <= fc_s1;
		end
	end

	logic drop_sat;
	assign drop_sat = fc_sat_s2 || (({ksat_s2, {FB{1'b0}}} >> DB) >= SW'(den_fc_s2));

	// stored water below the front
	logic [SW-1:0] store_s3;
	always_ff @(posedge clk) begin
		if (en) store_s3 <= SW'(dl_s2) * SW'(a_s2);
	end

	// lambda divider: 2^29 / lambda
	logic [EN_W-1:0] e_num;
	logic [E_QW-1:0] e_quo;
	logic [E_W-1:0]  e_c, e_d;

	assign e_num = EN_W'(E_NUM);

	sbp_div #(.DW(LAMBDA_W), .QW(E_QW)) u_div_e (
		.clk(clk), .en(en), .num(e_num), .den(lam_s2), .quo(e_quo)
	);

	assign e_c = E_W'(E_BASE) + E_W'(e_quo);

	sbp_delay #(.W(E_W), .N(TM - E_QW)) u_dly_e (
		.clk(clk), .en(en), .d(e_c), .q(e_d)
	);

	// relative saturation
	logic [FB-1:0] se_quo;
	logic          se_full_d;
	logic [FB:0]   se_c;

	sbp_div #(.DW(FB), .QW(FB)) u_div_se (
		.clk(clk), .en(en), .num({a_s2, {FB{1'b0}}}), .den(den_se_s2), .quo(se_quo)
	);

	sbp_delay #(.W(1), .N(FB)) u_dly_full (
		.clk(clk), .en(en), .d(se_full_s2), .q(se_full_d)
	);

	assign se_c = se_full_d ? ((FB+1)'(1) << FB) : {1'b0, se_quo};

	logic [NBW-1:0]      lg_n, lg_n_d;
	logic [LOG_FRAC-1:0] lg_frac, lg_frac_d;

	sbp_log #(.FRACTION_BITS(FB)) u_log (
		.clk(clk), .en(en), .se(se_c), .n(lg_n), .frac(lg_frac)
	);

	sbp_delay #(.W(NBW + LOG_FRAC), .N(TM - T_LOG)) u_dly_log (
		.clk(clk), .en(en), .d({lg_n, lg_frac}), .q({lg_n_d, lg_frac_d})
	);

	// exponent times log
	logic [LW-1:0]       lg_l;
	logic [E_W+LW-1:0]   el_prod;
	logic [PRW-1:0]      p_s36;

	assign lg_l    = {lg_n_d, {LOG_FRAC{1'b0}}} - LW'(lg_frac_d);
	assign el_prod = (E_W+LW)'(e_d) * (E_W+LW)'(lg_l);

	always_ff @(posedge clk) begin
		if (en) p_s36 <= el_prod[E_W+LW-1:LOG_FRAC];
	end

	logic [EXP_R_W-1:0] ex_r, ex_sh;
	logic [IW-1:0]      ex_ip;

	sbp_exp #(.P_W(PRW)) u_exp (
		.clk(clk), .en(en), .p(p_s36), .r(ex_r), .ip(ex_ip)
	);

	assign ex_sh = ex_r >> ex_ip[5:0];

	logic [FB:0]         pw_s53;
	logic [DB-1:0]       ksat_pw;
	logic [SW:0]         kp_prod;
	logic [DB-1:0]       perc_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			pw_s53 <= (ex_ip >= IW'(EXP_LIMIT)) ? '0 :
				ex_sh[EXP_C_W-FB+FB:EXP_C_W-FB];
		end
	end

	sbp_delay #(.W(DB), .N(T_PW)) u_dly_kp (
		.clk(clk), .en(en), .d(ksat_s2), .q(ksat_pw)
	);

	assign kp_prod = (SW+1)'(ksat_pw) * (SW+1)'(pw_s53);

	always_ff @(posedge clk) begin
		if (en) perc_s54 <= kp_prod[SW-1:FB];
	end

	// limit by stored water
	logic [SW-1:0] store_d;
	logic [DB-1:0] avail, perc_lim, dl_d;
	logic [DB-1:0] pm_s55;
	logic [SW-1:0] rem_s55;

	sbp_delay #(.W(SW), .N(T_PERC - 1)) u_dly_store (
		.clk(clk), .en(en), .d(store_s3), .q(store_d)
	);

	assign avail    = store_d[SW-1:FB];
	assign perc_lim = (perc_s54 > avail) ? avail : perc_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s55  <= perc_lim;
			rem_s55 <= store_d - {perc_lim, {FB{1'b0}}};
		end
	end

	sbp_delay #(.W(DB), .N(T_MIN)) u_dly_dl (
		.clk(clk), .en(en), .d(dl_s2), .q(dl_d)
	);

	logic [FB-1:0] th_quo;
	logic [DB-1:0] pm_d;

	sbp_div #(.DW(DB), .QW(FB)) u_div_th (
		.clk(clk), .en(en), .num(rem_s55), .den(dl_d), .quo(th_quo)
	);

	sbp_delay #(.W(DB), .N(FB)) u_dly_pm (
		.clk(clk), .en(en), .d(pm_s55), .q(pm_d)
	);

	// front drop
	logic [DB-1:0] drop_quo, drop_d;

	sbp_div #(.DW(FB), .QW(DB)) u_div_drop (
		.clk(clk), .en(en), .num({ksat_s2, {FB{1'b0}}}), .den(den_fc_s2), .quo(drop_quo)
	);

	sbp_delay #(.W(DB), .N(TF - DB)) u_dly_drop (
		.clk(clk), .en(en), .d(drop_quo), .q(drop_d)
	);

	// side data to the end
	side_t side_in, sd;

	assign side_in = '{tag: tag_s2, front: front_s2, theta: theta_s2, thr: thr_s2,
		fc: fc_s2, ksat: ksat_s2, skip: skip_s2, fb: fb_s2, dlz: dlz_s2, dsat: drop_sat};

	sbp_delay #(.W($bits(side_t)), .N(TF)) u_dly_side (
		.clk(clk), .en(en), .d(side_in), .q(sd)
	);

	// result select
	logic [DB-1:0] drop;
	logic [DB-1:0] perc_c, front_c;
	logic [FB-1:0] theta_c;

	assign drop = sd.dsat ? {DB{1'b1}} : drop_d;

	always_comb begin
		perc_c  = '0;
		theta_c = sd.theta;
		front_c = sd.front;
		if (sd.skip || (sd.fb && sd.dlz)) begin
			perc_c = '0;
		end else if (sd.fb) begin
			perc_c  = pm_d;
			theta_c = sd.thr + th_quo;
		end else begin
			perc_c  = sd.ksat;
			theta_c = sd.fc;
			front_c = (sd.front > drop) ? sd.front - drop : '0;
		end
	end

	logic [TAG_W-1:0] cell_tag_q;
	logic [DB-1:0]    percolation_q, front_next_q;
	logic [FB-1:0]    moisture_next_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cell_tag_q      <= sd.tag;
			percolation_q   <= perc_c;
			moisture_next_q <= theta_c;
			front_next_q    <= front_c;
		end
	end

	assign results.valid         = out_vld_q;
	assign results.cell_tag      = cell_tag_q;
	assign results.percolation   = percolation_q;
	assign results.moisture_next = moisture_next_q;
	assign results.front_next    = front_next_q;

	// checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved while stalled");

	a_front_recede: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[TF+1] |=> results.front_next <= $past(sd.front))
		else $error("front moved down");

	a_perc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[TF+1] |=> results.percolation <= $past(sd.ksat))
		else $error("percolation above scaled conductivity");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams soil cells through the bottom percolation pipeline under several
// idling phases and register settings, predicts each result in fixed point or
// takes it from a directed row, and compares it field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
	import sbp_pkg::*;

	localparam int FB = 16;
	localparam int DB = 24;
	localparam longint DMAX = (64'd1 << DB) - 1;
	localparam longint FONE = 64'd1 << FB;
	localparam int LAT = 71;

	typedef struct packed {
		logic [23:0] tag;
		logic [23:0] front;
		logic [15:0] pore;
		logic [15:0] thr;
		logic [15:0] theta;
		logic [15:0] fc;
		logic [19:0] cond;
		logic [13:0] lambda;
		logic [23:0] bottom;
		logic [23:0] top;
		logic [23:0] gw;
	} cell_t;

	typedef struct packed {
		logic [23:0] tag;
		logic [23:0] perc;
		logic [15:0] theta;
		logic [23:0] front;
	} drain_t;

	typedef struct {
		cell_t c;
		logic  known;
		drain_t r;
	} row_t;

	logic clk;
	logic arst_n;

	sbp_cell_if #(.FRACTION_BITS(FB), .DEPTH_BITS(DB)) cells();
	sbp_res_if  #(.FRACTION_BITS(FB), .DEPTH_BITS(DB)) results();
	sbp_cfg_if  cfg();

	soil_bottom_percolation #(.FRACTION_BITS(FB), .DEPTH_BITS(DB)) i_dut (
		.clk(clk), .arst_n(arst_n), .cells(cells.sink), .results(results.source),
		.cfg(cfg.sink)
	);

	logic [15:0] gain_q;
	logic [1:0]  lcount_q;
	logic        gw_en_q;
	logic [19:0] head_q;

	drain_t pending_drain[$];
	int     errors = 0;
	int     send_idle = 0;
	int     recv_stall = 0;
	bit     hold_off = 0;
	bit     hold_req = 0;

	logic [63:0] exp_c[1:16];

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] log2_inv(logic [63:0] se);
		logic [63:0] m;
		logic [63:0] n;
		logic [63:0] frac;
		m = se;
		n = 0;
		frac = 0;
		while (m < FONE) begin
			m = m << 1;
			n++;
		end
		for (int i = 1; i <= 16; i++) begin
			m = (m * m) >> FB;
			if (m >= 2 * FONE) begin
				m = m >> 1;
				frac |= 64'd1 << (16 - i);
			end
		end
		return (n << 16) - frac;
	endfunction

	function automatic logic [63:0] pow2_neg(logic [63:0] p);
		logic [63:0] ip;
		logic [63:0] r;
		ip = p >> 16;
		r = 64'd1 << 32;
		for (int i = 1; i <= 16; i++)
			if (p[16-i]) r = (r * exp_c[i]) >> 32;
		if (ip >= 33) return 0;
		r = r >> ip;
		return r >> (32 - FB);
	endfunction

	function automatic drain_t percolate(cell_t c);
		drain_t o;
		logic [63:0] top, ksat, se, lam, e, pw, perc, upper, dl, store, avail, drop;
		logic [63:0] theta, front;
		top = (lcount_q >= 2) ? c.top : 0;
		theta = c.theta;
		front = c.front;
		o.tag = c.tag;
		o.perc = 0;
		o.theta = c.theta;
		o.front = c.front;
		if (gw_en_q && $signed({40'd0, c.gw}) > $signed({40'd0, c.bottom}) -
				$signed({44'd0, head_q}))
			return o;
		if (c.theta <= c.thr) return o;
		ksat = (64'(c.cond) * gain_q) >> 12;
		if (ksat > DMAX) ksat = DMAX;
		if (c.pore > c.thr) begin
			se = (64'(c.theta - c.thr) << FB) / (c.pore - c.thr);
			if (se > FONE) se = FONE;
		end else begin
			se = FONE;
		end
		lam = (c.lambda == 0) ? 1 : c.lambda;
		e = (64'd3 << 16) + (64'd2 << 28) / lam;
		pw = (se == 0) ? 0 : pow2_neg((e * log2_inv(se)) >> 16);
		perc = (ksat * pw) >> FB;
		if (front + 1000 < c.bottom) begin
			upper = (top > front) ? top : front;
			if (upper >= c.bottom) return o;
			dl = c.bottom - upper;
			store = dl * (c.theta - c.thr);
			avail = store >> FB;
			if (perc > avail) perc = avail;
			theta = c.thr + (store - (perc << FB)) / dl;
		end else begin
			if (c.pore > c.fc) begin
				drop = (ksat << FB) / (c.pore - c.fc);
				if (drop > DMAX) drop = DMAX;
			end else begin
				drop = DMAX;
			end
			theta = c.fc;
			front = (front > drop) ? front - drop : 0;
			perc = ksat;
		end
		o.perc = perc[23:0];
		o.theta = theta[15:0];
		o.front = front[23:0];
		return o;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Simulation FAILED");
		$finish;
	end

	// long receiver hold-off, counted here
	initial begin
		wait (hold_req);
		hold_off = 1;
		repeat (200) @(posedge clk);
		hold_off = 0;
	end

	// receiver: random stall or a long hold-off
	always @(posedge clk) begin
		if (hold_off) results.ready <= 1'b0;
		else results.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		drain_t want;
		if (arst_n && results.valid && results.ready) begin
			if (pending_drain.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result tag %h", results.cell_tag);
			end else begin
				want = pending_drain.pop_front();
				if (want != {results.cell_tag, results.percolation, results.moisture_next,
						results.front_next}) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp %h/%h/%h/%h got %h/%h/%h/%h", want.tag,
							want.perc, want.theta, want.front, results.cell_tag,
							results.percolation, results.moisture_next, results.front_next);
				end
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [19:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_GAIN:   gain_q = val[15:0];
			REG_LCOUNT: lcount_q = val[1:0];
			REG_GW_EN:  gw_en_q = val[0];
			REG_HEAD:   head_q = val;
			default: ;
		endcase
	endtask

	task automatic drain_all();
		while (pending_drain.size() != 0) @(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	task automatic send_cell(cell_t c, logic known, drain_t r);
		while ($urandom_range(99) < send_idle) begin
			cells.valid <= 1'b0;
			@(posedge clk);
		end
		{cells.cell_index, cells.front_depth, cells.porosity, cells.residual_moisture,
			cells.moisture_now, cells.field_capacity, cells.conductivity, cells.pore_index,
			cells.layer_bottom, cells.layer_top, cells.groundwater_height} <= c;
		cells.valid <= 1'b1;
		pending_drain.push_back(known ? r : percolate(c));
		@(posedge clk);
		while (!cells.ready) @(posedge clk);
	endtask

	function automatic cell_t rand_cell();
		cell_t c;
		logic [15:0] a, b;
		c = cell_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		c.bottom = $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000, 100);
		case ($urandom_range(3))
			0: c.front = c.bottom + $urandom_range(1000);
			1: c.front = $urandom_range(c.bottom);
			default: ;
		endcase
		if ($urandom_range(1)) c.top = $urandom_range(c.bottom);
		if ($urandom_range(3) != 0) begin
			a = $urandom_range(20000);
			b = $urandom_range(65535, a);
			c.thr = a;
			c.pore = b;
			c.theta = $urandom_range(b, a);
			c.fc = $urandom_range(b, a);
			c.lambda = $urandom_range(16383, 205);
		end
		if ($urandom_range(3) == 0) c.gw = $urandom_range(c.bottom);
		return c;
	endfunction

	row_t dir_rows[$];

	initial begin
		cell_t c;
		row_t row;
		drain_t nr;
		int n;
		logic [19:0] gains[4] = '{20'd4096, 20'd0, 20'd65535, 20'd2000};

		exp_c[1] = root64(64'h8000_0000_0000_0000);
		for (int k = 2; k <= 16; k++) exp_c[k] = root64(exp_c[k-1] << 32);
		arst_n = 0;
		cells.valid = 0;
		cells.cell_index = 0;
		cells.front_depth = 0;
		cells.porosity = 0;
		cells.residual_moisture = 0;
		cells.moisture_now = 0;
		cells.field_capacity = 0;
		cells.conductivity = 0;
		cells.pore_index = 0;
		cells.layer_bottom = 0;
		cells.layer_top = 0;
		cells.groundwater_height = 0;
		results.ready = 0;
		cfg.valid = 0;
		cfg.index = REG_GAIN;
		cfg.data = 0;
		gain_q = GAIN_RST;
		lcount_q = LCOUNT_RST;
		gw_en_q = 0;
		head_q = HEAD_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table; known rows: dry layer and zero-span cases
		c = '0;
		c.tag = 24'hFFFFFF; c.front = 24'hFFFFFF; c.theta = 16'h8000; c.thr = 16'h8000;
		nr = {c.tag, 24'd0, c.theta, c.front};
		dir_rows.push_back('{c, 1'b1, nr});
		c = '0;
		c.tag = 1; c.theta = 0; c.thr = 16'hFFFF; c.cond = 20'hFFFFF;
		nr = {c.tag, 24'd0, 16'd0, 24'd0};
		dir_rows.push_back('{c, 1'b1, nr});
		c = '{tag: 2, front: 0, pore: 16'hFFFF, thr: 0, theta: 16'hFFFF, fc: 16'h4000,
			cond: 20'hFFFFF, lambda: 14'h3FFF, bottom: 24'hFFFFFF, top: 0, gw: 0};
		dir_rows.push_back('{c, 1'b0, nr});
		c.lambda = 0; c.tag = 3;
		dir_rows.push_back('{c, 1'b0, nr});
		c.lambda = 205; c.tag = 4; c.theta = 1; c.pore = 16'hFFFF;
		dir_rows.push_back('{c, 1'b0, nr});
		c.tag = 5; c.pore = 0; c.thr = 0; c.theta = 100; c.front = 5000; c.bottom = 5000;
		dir_rows.push_back('{c, 1'b0, nr});
		c.tag = 6; c.pore = 16'h1000; c.fc = 16'h2000; c.front = 24'hFFFFFF;
		dir_rows.push_back('{c, 1'b0, nr});
		c.tag = 7; c.pore = 16'hFFFF; c.fc = 16'hFFFF; c.front = 100; c.bottom = 1100;
		dir_rows.push_back('{c, 1'b0, nr});
		c.tag = 8; c.front = 100; c.bottom = 1101;
		dir_rows.push_back('{c, 1'b0, nr});
		c.tag = 9; c.front = 24'hFFFFFF - 2000; c.bottom = 24'hFFFFFF; c.gw = 24'hFFFFFF;
		dir_rows.push_back('{c, 1'b0, nr});
		c.tag = 10; c.bottom = 0; c.front = 0; c.cond = 0;
		dir_rows.push_back('{c, 1'b0, nr});

		foreach (dir_rows[i]) send_cell(dir_rows[i].c, dir_rows[i].known, dir_rows[i].r);
		cells.valid <= 1'b0;
		drain_all();

		// groundwater and multi-layer rows under the opposite settings
		write_reg(REG_LCOUNT, 3);
		write_reg(REG_GW_EN, 1);
		write_reg(REG_HEAD, 20'hFFFFF);
		write_reg(REG_GAIN, 65535);
		c = '{tag: 11, front: 0, pore: 16'hFFFF, thr: 0, theta: 16'h8000, fc: 0,
			cond: 20'hFFFFF, lambda: 4096, bottom: 2000000, top: 0, gw: 1000000};
		nr = {c.tag, 24'd0, c.theta, c.front};
		send_cell(c, 1'b1, nr);
		c.tag = 12; c.gw = 0; c.top = 24'hFFFFFF;
		nr = {c.tag, 24'd0, c.theta, c.front};
		cells.valid <= 1'b0;
		drain_all();
		write_reg(REG_HEAD, 0);
		send_cell(c, 1'b1, nr);
		c.tag = 13; c.top = 500000; c.gw = 24'hFFFFFF;
		c.bottom = 24'hFFFFFF;
		send_cell(c, 1'b0, nr);
		cells.valid <= 1'b0;
		drain_all();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_GAIN, gains[ph % 4]);
			write_reg(REG_LCOUNT, ph % 4);
			write_reg(REG_GW_EN, ph[0] ^ ph[2]);
			write_reg(REG_HEAD, (ph == 5) ? 20'hFFFFF : $urandom_range(20000));
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 46; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 46; end
				default: begin send_idle = 38; recv_stall = 38; end
			endcase
			n = 115;
			for (int i = 0; i < n; i++) begin
				if (ph == 2 && i == 10) hold_req = 1;
				send_cell(rand_cell(), 1'b0, nr);
			end
			cells.valid <= 1'b0;
			drain_all();
		end

		drain_all();
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== soil_bottom_percolation.f =====
rtl/sbp_pkg.sv
rtl/sbp_if.sv
rtl/sbp_delay.sv
rtl/sbp_div.sv
rtl/sbp_log.sv
rtl/sbp_exp.sv
rtl/soil_bottom_percolation.sv
tb/sv/testbench.sv
